// ----- hw/rtl/lciw_pkg.sv -----
// Shared types and constants for the 8080 panel command/window writer.
// Used by lciw_front, lciw_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package lciw_pkg;

  // Operation codes on the request port
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_WINDOW = 3'd1,
    OP_PIXEL  = 3'd2,
    OP_MIRROR = 3'd3,
    OP_SWAP   = 3'd4,
    OP_INVERT = 3'd5,
    OP_ONOFF  = 3'd6,
    OP_SLEEP  = 3'd7
  } op_e;

  // Job kinds handed from front to back
  typedef enum logic [2:0] {
    JOB_INIT   = 3'd0,
    JOB_WINDOW = 3'd1,
    JOB_PIXEL  = 3'd2,
    JOB_MODE   = 3'd3,
    JOB_SINGLE = 3'd4
  } job_kind_e;

  // Configuration register indexes
  localparam logic [2:0] REG_BGR_SELECT  = 3'd0;
  localparam logic [2:0] REG_MIRROR_COL  = 3'd1;
  localparam logic [2:0] REG_MIRROR_ROW  = 3'd2;
  localparam logic [2:0] REG_SWAP_AXES   = 3'd3;
  localparam logic [2:0] REG_INVERT      = 3'd4;
  localparam logic [2:0] REG_COL_OFFSET  = 3'd5;
  localparam logic [2:0] REG_ROW_OFFSET  = 3'd6;

  // Panel command bytes
  localparam logic [7:0] CMD_SWRESET = 8'h01;
  localparam logic [7:0] CMD_SLPIN   = 8'h10;
  localparam logic [7:0] CMD_SLPOUT  = 8'h11;
  localparam logic [7:0] CMD_INVOFF  = 8'h20;
  localparam logic [7:0] CMD_INVON   = 8'h21;
  localparam logic [7:0] CMD_DISPOFF = 8'h28;
  localparam logic [7:0] CMD_DISPON  = 8'h29;
  localparam logic [7:0] CMD_CASET   = 8'h2A;
  localparam logic [7:0] CMD_RASET   = 8'h2B;
  localparam logic [7:0] CMD_RAMWR   = 8'h2C;
  localparam logic [7:0] CMD_MADCTL  = 8'h36;
  localparam logic [7:0] CMD_COLMOD  = 8'h3A;
  localparam logic [7:0] CMD_RAMCTRL = 8'hB0;
  localparam logic [7:0] PAR_COLMOD  = 8'h55;
  localparam logic [7:0] PAR_RAMCTL0 = 8'h00;
  localparam logic [7:0] PAR_RAMCTL1 = 8'hF8;

  localparam int unsigned CountW     = 22;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
  localparam int unsigned OffsetW    = 9;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned StepW      = 4;

  localparam int unsigned JOB_DEPTH_DEFAULT = 2;
  localparam int unsigned OUT_DEPTH_DEFAULT = 2;

  typedef struct packed {
    job_kind_e         kind;
    logic [7:0]        byte_val;  // pixel byte, mode byte or single command
    logic              flag;      // pixel last / init invert / window count zero
    logic [CoordW-1:0] col_a;
    logic [CoordW-1:0] col_b;
    logic [CoordW-1:0] row_a;
    logic [CoordW-1:0] row_b;
  } job_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_value;
    logic       eot;
  } wr_t;

endpackage

// ----- hw/rtl/lciw_queue.sv -----
// Small first-in first-out queue of flat words.
// Depends on nothing; used between front, back and the result port.
`timescale 1ns / 1ps

module lciw_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/lciw_front.sv -----
// Front end: holds configuration, address mode and pixel byte count,
// classifies each request and posts a job. Depends on lciw_pkg.
`timescale 1ns / 1ps

module lciw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lciw_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lciw_pkg::OffsetW-1:0]  cfg_data_i,
  input  logic                          req_i,
  input  logic [2:0]                    op_i,
  input  logic [9:0]                    col_first_i,
  input  logic [9:0]                    row_first_i,
  input  logic [10:0]                   col_past_end_i,
  input  logic [10:0]                   row_past_end_i,
  input  logic [7:0]                    pixel_value_i,
  input  logic                          flag_one_i,
  input  logic                          flag_two_i,
  output logic                          job_push_o,
  output lciw_pkg::job_t                job_o
);

  logic                           bgr_q, mir_col_q, mir_row_q, swap_q, inv_q;
  logic [lciw_pkg::OffsetW-1:0]   col_off_q, row_off_q;
  logic [7:0]                     amode_q, amode_d;
  logic [lciw_pkg::CountW-1:0]    left_q, left_d;

  logic [lciw_pkg::CoordW-1:0]    col_off_x, row_off_x;
  logic [10:0]                    col_span, row_span;
  logic [21:0]                    area;
  logic [lciw_pkg::CountW-1:0]    win_count;
  logic                           win_pos;

  assign col_off_x = {{(lciw_pkg::CoordW - lciw_pkg::OffsetW){col_off_q[lciw_pkg::OffsetW-1]}},
                      col_off_q};
  assign row_off_x = {{(lciw_pkg::CoordW - lciw_pkg::OffsetW){row_off_q[lciw_pkg::OffsetW-1]}},
                      row_off_q};

  assign win_pos  = (col_past_end_i > {1'b0, col_first_i}) &&
                    (row_past_end_i > {1'b0, row_first_i});
  assign col_span = col_past_end_i - {1'b0, col_first_i};
  assign row_span = row_past_end_i - {1'b0, row_first_i};
  assign area     = {11'b0, col_span} * {11'b0, row_span};
  // Doubled area saturates once bit 21 of the area is set
  assign win_count = !win_pos ? '0 :
                     area[21] ? lciw_pkg::COUNT_MAX : {area[20:0], 1'b0};

  always_comb begin
    amode_d    = amode_q;
    left_d     = left_q;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.col_a = 16'({6'b0, col_first_i}) + col_off_x;
    job_o.col_b = 16'({5'b0, col_past_end_i}) + col_off_x - 16'd1;
    job_o.row_a = 16'({6'b0, row_first_i}) + row_off_x;
    job_o.row_b = 16'({5'b0, row_past_end_i}) + row_off_x - 16'd1;
    if (req_i) begin
      if (lciw_pkg::op_e'(op_i) != lciw_pkg::OP_PIXEL) begin
        left_d = '0;
      end
      case (lciw_pkg::op_e'(op_i))
        lciw_pkg::OP_PIXEL: begin
          // Drop the byte when no window count is left
          if (left_q != '0) begin
            left_d         = left_q - 1'b1;
            job_push_o     = 1'b1;
            job_o.kind     = lciw_pkg::JOB_PIXEL;
            job_o.byte_val = pixel_value_i;
            job_o.flag     = (left_q == lciw_pkg::CountW'(1));
          end
        end
        lciw_pkg::OP_INIT: begin
          amode_d        = {mir_row_q, mir_col_q, swap_q, 1'b0, bgr_q, 3'b000};
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_INIT;
          job_o.byte_val = amode_d;
          job_o.flag     = inv_q;
        end
        lciw_pkg::OP_WINDOW: begin
          left_d     = win_count;
          job_push_o = 1'b1;
          job_o.kind = lciw_pkg::JOB_WINDOW;
          job_o.flag = (win_count == '0);
        end
        lciw_pkg::OP_MIRROR: begin
          amode_d        = {flag_two_i, flag_one_i, amode_q[5:0]};
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_MODE;
          job_o.byte_val = amode_d;
        end
        lciw_pkg::OP_SWAP: begin
          amode_d        = {amode_q[7:6], flag_one_i, amode_q[4:0]};
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_MODE;
          job_o.byte_val = amode_d;
        end
        lciw_pkg::OP_INVERT: begin
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_SINGLE;
          job_o.byte_val = flag_one_i ? lciw_pkg::CMD_INVON : lciw_pkg::CMD_INVOFF;
        end
        lciw_pkg::OP_ONOFF: begin
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_SINGLE;
          job_o.byte_val = flag_one_i ? lciw_pkg::CMD_DISPON : lciw_pkg::CMD_DISPOFF;
        end
        lciw_pkg::OP_SLEEP: begin
          job_push_o     = 1'b1;
          job_o.kind     = lciw_pkg::JOB_SINGLE;
          job_o.byte_val = flag_one_i ? lciw_pkg::CMD_SLPIN : lciw_pkg::CMD_SLPOUT;
        end
        default: begin
          job_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bgr_q     <= 1'b0;
      mir_col_q <= 1'b0;
      mir_row_q <= 1'b0;
      swap_q    <= 1'b0;
      inv_q     <= 1'b0;
      col_off_q <= '0;
      row_off_q <= '0;
      amode_q   <= '0;
      left_q    <= '0;
    end else begin
      amode_q <= amode_d;
      left_q  <= left_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          lciw_pkg::REG_BGR_SELECT: bgr_q     <= cfg_data_i[0];
          lciw_pkg::REG_MIRROR_COL: mir_col_q <= cfg_data_i[0];
          lciw_pkg::REG_MIRROR_ROW: mir_row_q <= cfg_data_i[0];
          lciw_pkg::REG_SWAP_AXES:  swap_q    <= cfg_data_i[0];
          lciw_pkg::REG_INVERT:     inv_q     <= cfg_data_i[0];
          lciw_pkg::REG_COL_OFFSET: col_off_q <= cfg_data_i;
          lciw_pkg::REG_ROW_OFFSET: row_off_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/lciw_back.sv -----
// Back end: walks the head job byte by byte and posts bus writes.
// Depends on lciw_pkg.
`timescale 1ns / 1ps

module lciw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  lciw_pkg::job_t  job_i,
  output logic            job_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output lciw_pkg::wr_t   wr_o
);

  logic [lciw_pkg::StepW-1:0] step_q, step_d;
  logic                       final_step;

  always_comb begin
    wr_o       = '0;
    final_step = 1'b0;
    case (job_i.kind)
      lciw_pkg::JOB_PIXEL: begin
        wr_o       = '{is_data: 1'b1, bus_value: job_i.byte_val, eot: job_i.flag};
        final_step = 1'b1;
      end
      lciw_pkg::JOB_SINGLE: begin
        wr_o       = '{is_data: 1'b0, bus_value: job_i.byte_val, eot: 1'b1};
        final_step = 1'b1;
      end
      lciw_pkg::JOB_MODE: begin
        if (step_q == '0) begin
          wr_o = '{is_data: 1'b0, bus_value: lciw_pkg::CMD_MADCTL, eot: 1'b0};
        end else begin
          wr_o       = '{is_data: 1'b1, bus_value: job_i.byte_val, eot: 1'b1};
          final_step = 1'b1;
        end
      end
      lciw_pkg::JOB_INIT: begin
        case (step_q)
          4'd0: wr_o = '{1'b0, lciw_pkg::CMD_SWRESET, 1'b1};
          4'd1: wr_o = '{1'b0, lciw_pkg::CMD_SLPOUT, 1'b1};
          4'd2: wr_o = '{1'b0, lciw_pkg::CMD_MADCTL, 1'b0};
          4'd3: wr_o = '{1'b1, job_i.byte_val, 1'b1};
          4'd4: wr_o = '{1'b0, lciw_pkg::CMD_COLMOD, 1'b0};
          4'd5: wr_o = '{1'b1, lciw_pkg::PAR_COLMOD, 1'b1};
          4'd6: wr_o = '{1'b0, lciw_pkg::CMD_RAMCTRL, 1'b0};
          4'd7: wr_o = '{1'b1, lciw_pkg::PAR_RAMCTL0, 1'b0};
          4'd8: wr_o = '{1'b1, lciw_pkg::PAR_RAMCTL1, 1'b1};
          4'd9: wr_o = '{1'b0, lciw_pkg::CMD_INVON, 1'b1};
          default: begin
            wr_o       = '{1'b0, lciw_pkg::CMD_DISPON, 1'b1};
            final_step = 1'b1;
          end
        endcase
      end
      lciw_pkg::JOB_WINDOW: begin
        case (step_q)
          4'd0: wr_o = '{1'b0, lciw_pkg::CMD_CASET, 1'b0};
          4'd1: wr_o = '{1'b1, job_i.col_a[15:8], 1'b0};
          4'd2: wr_o = '{1'b1, job_i.col_a[7:0], 1'b0};
          4'd3: wr_o = '{1'b1, job_i.col_b[15:8], 1'b0};
          4'd4: wr_o = '{1'b1, job_i.col_b[7:0], 1'b1};
          4'd5: wr_o = '{1'b0, lciw_pkg::CMD_RASET, 1'b0};
          4'd6: wr_o = '{1'b1, job_i.row_a[15:8], 1'b0};
          4'd7: wr_o = '{1'b1, job_i.row_a[7:0], 1'b0};
          4'd8: wr_o = '{1'b1, job_i.row_b[15:8], 1'b0};
          4'd9: wr_o = '{1'b1, job_i.row_b[7:0], 1'b1};
          default: begin
            // Memory write closes itself when no pixel byte will follow
            wr_o       = '{1'b0, lciw_pkg::CMD_RAMWR, job_i.flag};
            final_step = 1'b1;
          end
        endcase
      end
      default: final_step = 1'b1;
    endcase
  end

  assign out_push_o = job_valid_i && !out_full_i;
  assign job_pop_o  = out_push_o && final_step;

  always_comb begin
    step_d = step_q;
    if (out_push_o) begin
      if (final_step) begin
        step_d = '0;
      end else if (job_i.kind == lciw_pkg::JOB_INIT && step_q == 4'd8 && !job_i.flag) begin
        // Skip the inversion command when start-up inversion is off
        step_d = 4'd10;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- hw/rtl/lcd_i8080_command_window_writer_core.sv -----
// Top level of the 8080 panel command/window writer.
// Depends on lciw_pkg, lciw_queue, lciw_front and lciw_back.
`timescale 1ns / 1ps

// Channel     | Handshake                 | Payload
// ------------+---------------------------+---------------------------------------------
// request in  | push, full                | op_i, window corners, pixel_value_i, flags
// write out   | empty, pop                | is_data_o, bus_value_o, end_of_transaction_o
// config      | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Pixel bytes flow at one per cycle: the front takes a request each cycle the
// job queue has room, and the back sequencer emits one bus write per cycle
// while the result queue has room. Command requests expand into 1 to 11 bus
// writes in the back sequencer; the front accepts until the job queue fills.
// Reset clears all control state; there is no clearing pass. Either side may
// stall: the job queue and the result queue absorb it without losing a write.

module lcd_i8080_command_window_writer_core #(
  parameter int unsigned JobDepth = lciw_pkg::JOB_DEPTH_DEFAULT,
  parameter int unsigned OutDepth = lciw_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           push,
  output logic                           full,
  input  logic [2:0]                     op_i,
  input  logic [9:0]                     col_first_i,
  input  logic [9:0]                     row_first_i,
  input  logic [10:0]                    col_past_end_i,
  input  logic [10:0]                    row_past_end_i,
  input  logic [7:0]                     pixel_value_i,
  input  logic                           flag_one_i,
  input  logic                           flag_two_i,
  // bus write channel
  output logic                           empty,
  input  logic                           pop,
  output logic                           is_data_o,
  output logic [7:0]                     bus_value_o,
  output logic                           end_of_transaction_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lciw_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lciw_pkg::OffsetW-1:0]   cfg_data_i
);

  localparam int unsigned JobW = $bits(lciw_pkg::job_t);
  localparam int unsigned WrW  = $bits(lciw_pkg::wr_t);

  logic            req_acc;
  logic            job_push, job_full, job_empty, job_pop;
  lciw_pkg::job_t  job_in, job_head;
  logic [JobW-1:0] job_head_raw;
  logic            out_push, out_full;
  lciw_pkg::wr_t   wr_in, wr_head;
  logic [WrW-1:0]  wr_head_raw;

  // Configuration is always taken at once
  assign cfg_ready_o = 1'b1;
  assign full        = job_full;
  assign req_acc     = push && !job_full;

  lciw_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .req_i          (req_acc),
    .op_i,
    .col_first_i,
    .row_first_i,
    .col_past_end_i,
    .row_past_end_i,
    .pixel_value_i,
    .flag_one_i,
    .flag_two_i,
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  // Job queue: parts request acceptance from byte sequencing
  lciw_queue #(
    .Width (JobW),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i,
    .rst_ni,
    .push_i  (job_push),
    .wdata_i (JobW'(job_in)),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_head_raw),
    .empty_o (job_empty)
  );

  assign job_head = lciw_pkg::job_t'(job_head_raw);

  lciw_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (!job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .wr_o        (wr_in)
  );

  // Result queue: holds finished writes while the consumer stalls
  lciw_queue #(
    .Width (WrW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .wdata_i (WrW'(wr_in)),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (wr_head_raw),
    .empty_o (empty)
  );

  assign wr_head              = lciw_pkg::wr_t'(wr_head_raw);
  assign is_data_o            = wr_head.is_data;
  assign bus_value_o          = wr_head.bus_value;
  assign end_of_transaction_o = wr_head.eot;

  // Back end never writes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("bus write pushed into full result queue");

  // A job retires only together with its last bus write
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> out_push && !job_empty)
    else $error("job retired without a bus write");

  // No bus write appears without a pending job
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_empty |-> !out_push)
    else $error("bus write produced with empty job queue");

endmodule

// ----- tb/lcd_i8080_command_window_writer_core_test.sv -----
// Self-checking test of lcd_i8080_command_window_writer_core: drives display requests and
// register writes, predicts every panel bus write and checks the write stream in order.
// Depends on lciw_pkg and the writer core RTL.
`timescale 1ns / 1ps

module lcd_i8080_command_window_writer_core_test;
  import lciw_pkg::*;

  // Cycles to let pass after the last expected write before touching registers or ending:
  // a command expands into up to 11 bus writes and both queues are two deep.
  localparam int SETTLE_CYCLES = 32;
  localparam int ITEMS_PER_PHASE = 65;

  typedef struct {
    op_e         op;
    logic [9:0]  col_first;
    logic [9:0]  row_first;
    logic [10:0] col_past_end;
    logic [10:0] row_past_end;
    logic [7:0]  pixel_value;
    logic        flag_one;
    logic        flag_two;
  } panel_req_t;

  // Predicts the bus writes each accepted request causes and matches them against the
  // writes popped from the block, oldest first.
  class bus_write_tracker;
    logic        bgr_select, start_mirror_col, start_mirror_row, start_swap_axes;
    logic        start_invert;
    logic [8:0]  col_offset, row_offset;
    logic [7:0]  address_mode;
    logic [21:0] bytes_left;
    wr_t         pending_writes[$];
    int          fails;
    int          writing_requests;

    function new();
      {bgr_select, start_mirror_col, start_mirror_row, start_swap_axes, start_invert} = '0;
      col_offset = '0;
      row_offset = '0;
      address_mode = '0;
      bytes_left = '0;
      fails = 0;
      writing_requests = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [OffsetW-1:0] data);
      case (idx)
        REG_BGR_SELECT: bgr_select = data[0];
        REG_MIRROR_COL: start_mirror_col = data[0];
        REG_MIRROR_ROW: start_mirror_row = data[0];
        REG_SWAP_AXES:  start_swap_axes = data[0];
        REG_INVERT:     start_invert = data[0];
        REG_COL_OFFSET: col_offset = data;
        REG_ROW_OFFSET: row_offset = data;
        default: ;
      endcase
    endfunction

    function void add(logic is_data, logic [7:0] value, logic eot);
      wr_t w;
      w.is_data = is_data;
      w.bus_value = value;
      w.eot = eot;
      pending_writes.push_back(w);
    endfunction

    // Address command: command byte, then start and end coordinates, high byte first.
    function void add_coords(logic [7:0] cmd, logic [9:0] first, logic [10:0] past,
                             logic [8:0] off);
      logic [15:0] soff, lo, hi;
      soff = {{7{off[8]}}, off};
      lo = {6'b0, first} + soff;
      hi = {5'b0, past} + soff - 16'd1;
      add(1'b0, cmd, 1'b0);
      add(1'b1, lo[15:8], 1'b0);
      add(1'b1, lo[7:0], 1'b0);
      add(1'b1, hi[15:8], 1'b0);
      add(1'b1, hi[7:0], 1'b1);
    endfunction

    function void take_request(panel_req_t r);
      int unsigned cnt;
      int          prior_size;
      prior_size = pending_writes.size();
      if (r.op == OP_PIXEL) begin
        if (bytes_left != 0) begin
          bytes_left = bytes_left - 22'd1;
          add(1'b1, r.pixel_value, bytes_left == 0);
        end
      end else begin
        // Any command abandons an open pixel stream.
        bytes_left = '0;
        case (r.op)
          OP_INIT: begin
            address_mode = {start_mirror_row, start_mirror_col, start_swap_axes, 1'b0,
                            bgr_select, 3'b000};
            add(1'b0, CMD_SWRESET, 1'b1);
            add(1'b0, CMD_SLPOUT, 1'b1);
            add(1'b0, CMD_MADCTL, 1'b0);
            add(1'b1, address_mode, 1'b1);
            add(1'b0, CMD_COLMOD, 1'b0);
            add(1'b1, PAR_COLMOD, 1'b1);
            add(1'b0, CMD_RAMCTRL, 1'b0);
            add(1'b1, PAR_RAMCTL0, 1'b0);
            add(1'b1, PAR_RAMCTL1, 1'b1);
            if (start_invert) add(1'b0, CMD_INVON, 1'b1);
            add(1'b0, CMD_DISPON, 1'b1);
          end
          OP_WINDOW: begin
            add_coords(CMD_CASET, r.col_first, r.col_past_end, col_offset);
            add_coords(CMD_RASET, r.row_first, r.row_past_end, row_offset);
            cnt = 0;
            if (r.col_past_end > {1'b0, r.col_first} && r.row_past_end > {1'b0, r.row_first})
            begin
              cnt = (int'(r.col_past_end) - int'(r.col_first)) *
                    (int'(r.row_past_end) - int'(r.row_first)) * 2;
              if (cnt > COUNT_MAX) cnt = COUNT_MAX;
            end
            bytes_left = cnt[21:0];
            // An empty window closes the memory write at once.
            add(1'b0, CMD_RAMWR, bytes_left == 0);
          end
          OP_MIRROR: begin
            address_mode = {r.flag_two, r.flag_one, address_mode[5:0]};
            add(1'b0, CMD_MADCTL, 1'b0);
            add(1'b1, address_mode, 1'b1);
          end
          OP_SWAP: begin
            address_mode[5] = r.flag_one;
            add(1'b0, CMD_MADCTL, 1'b0);
            add(1'b1, address_mode, 1'b1);
          end
          OP_INVERT: add(1'b0, r.flag_one ? CMD_INVON : CMD_INVOFF, 1'b1);
          OP_ONOFF:  add(1'b0, r.flag_one ? CMD_DISPON : CMD_DISPOFF, 1'b1);
          default:   add(1'b0, r.flag_one ? CMD_SLPIN : CMD_SLPOUT, 1'b1);
        endcase
      end
      if (pending_writes.size() > prior_size) writing_requests++;
    endfunction

    function void match_write(logic is_data, logic [7:0] value, logic eot);
      wr_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: is_data %0d bus_value %02h end_of_transaction %0d",
               is_data, value, eot);
        fails++;
        return;
      end
      w = pending_writes.pop_front();
      if (is_data !== w.is_data) begin
        $error("is_data: expected %0d, actual %0d", w.is_data, is_data);
        fails++;
      end
      if (value !== w.bus_value) begin
        $error("bus_value: expected %02h, actual %02h", w.bus_value, value);
        fails++;
      end
      if (eot !== w.eot) begin
        $error("end_of_transaction: expected %0d, actual %0d", w.eot, eot);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [2:0]           op_i;
  logic [9:0]           col_first_i;
  logic [9:0]           row_first_i;
  logic [10:0]          col_past_end_i;
  logic [10:0]          row_past_end_i;
  logic [7:0]           pixel_value_i;
  logic                 flag_one_i;
  logic                 flag_two_i;
  logic                 empty;
  logic                 pop;
  logic                 is_data_o;
  logic [7:0]           bus_value_o;
  logic                 end_of_transaction_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [OffsetW-1:0]   cfg_data_i;

  // While set, neither side idles.
  bit               steady;
  bus_write_tracker tracker;

  lcd_i8080_command_window_writer_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .op_i                (op_i),
    .col_first_i         (col_first_i),
    .row_first_i         (row_first_i),
    .col_past_end_i      (col_past_end_i),
    .row_past_end_i      (row_past_end_i),
    .pixel_value_i       (pixel_value_i),
    .flag_one_i          (flag_one_i),
    .flag_two_i          (flag_two_i),
    .empty               (empty),
    .pop                 (pop),
    .is_data_o           (is_data_o),
    .bus_value_o         (bus_value_o),
    .end_of_transaction_o(end_of_transaction_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Every field random within its range; callers override what matters.
  function automatic panel_req_t rand_request(op_e op);
    panel_req_t r;
    r.op = op;
    r.col_first = 10'($urandom_range(0, 1023));
    r.row_first = 10'($urandom_range(0, 1023));
    r.col_past_end = 11'($urandom_range(0, 1024));
    r.row_past_end = 11'($urandom_range(0, 1024));
    r.pixel_value = 8'($urandom);
    r.flag_one = 1'($urandom);
    r.flag_two = 1'($urandom);
    return r;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // acceptance, with push still high so back-to-back requests need no gap.
  task automatic send_request(panel_req_t r);
    while (!steady && $urandom_range(0, 99) < 17) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    op_i = r.op;
    col_first_i = r.col_first;
    row_first_i = r.row_first;
    col_past_end_i = r.col_past_end;
    row_past_end_i = r.row_past_end;
    pixel_value_i = r.pixel_value;
    flag_one_i = r.flag_one;
    flag_two_i = r.flag_two;
    do @(posedge clk_i); while (full);
    tracker.take_request(r);
    @(negedge clk_i);
  endtask

  task automatic put(op_e op, int cf, int rf, int ce, int re, int px, bit f1, bit f2);
    panel_req_t r;
    r.op = op;
    r.col_first = 10'(cf);
    r.row_first = 10'(rf);
    r.col_past_end = 11'(ce);
    r.row_past_end = 11'(re);
    r.pixel_value = 8'(px);
    r.flag_one = f1;
    r.flag_two = f2;
    send_request(r);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [OffsetW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Single-bit registers carry random upper data bits; only bit 0 counts.
  task automatic apply_settings(bit bgr, bit mcol, bit mrow, bit swap, bit inv,
                                logic [8:0] coff, logic [8:0] roff);
    write_reg(REG_BGR_SELECT, {8'($urandom), bgr});
    write_reg(REG_MIRROR_COL, {8'($urandom), mcol});
    write_reg(REG_MIRROR_ROW, {8'($urandom), mrow});
    write_reg(REG_SWAP_AXES, {8'($urandom), swap});
    write_reg(REG_INVERT, {8'($urandom), inv});
    write_reg(REG_COL_OFFSET, coff);
    write_reg(REG_ROW_OFFSET, roff);
  endtask

  // Hold requests until every predicted write has been popped, then let the block settle
  // for the given number of cycles (a dropped pixel may still be in flight).
  task automatic wait_drained(int settle);
    push = 1'b0;
    while (tracker.pending_writes.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Window edges: mostly a few pixels wide, sometimes against the far edge, sometimes
  // reversed so the size goes non-positive.
  function automatic void pick_span(output logic [9:0] first, output logic [10:0] past);
    int f, e;
    f = ($urandom_range(0, 9) == 0) ? $urandom_range(1019, 1023) : $urandom_range(0, 1023);
    if ($urandom_range(0, 9) == 0) e = $urandom_range(0, f);
    else e = f + $urandom_range(0, 4);
    if (e > 1024) e = 1024;
    first = 10'(f);
    past = 11'(e);
  endfunction

  task automatic random_phase(int goal, bit pause_midway);
    panel_req_t r;
    int         sel, npix, stop_at, mid;
    op_e        others[7];
    others = '{OP_INIT, OP_MIRROR, OP_SWAP, OP_INVERT, OP_ONOFF, OP_SLEEP, OP_PIXEL};
    stop_at = tracker.writing_requests + goal;
    mid = tracker.writing_requests + goal / 2;
    // Fresh start-up sequence under the new settings.
    send_request(rand_request(OP_INIT));
    while (tracker.writing_requests < stop_at) begin
      if (pause_midway && tracker.writing_requests >= mid) begin
        wait_drained(0);
        pause_midway = 1'b0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // Well-formed window followed by its pixel stream.
        r = rand_request(OP_WINDOW);
        pick_span(r.col_first, r.col_past_end);
        pick_span(r.row_first, r.row_past_end);
        send_request(r);
        npix = tracker.bytes_left;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: ;
          6, 7: npix += $urandom_range(1, 3);
          default: npix = $urandom_range(0, npix);
        endcase
        repeat (npix) send_request(rand_request(OP_PIXEL));
      end else if (sel < 75) begin
        // Wide random window, cut short by whatever comes next.
        send_request(rand_request(OP_WINDOW));
        repeat ($urandom_range(0, 5)) send_request(rand_request(OP_PIXEL));
      end else begin
        send_request(rand_request(others[$urandom_range(0, 6)]));
      end
    end
  endtask

  // Accept writes on rising edges; pop itself changes on falling edges.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      tracker.match_write(is_data_o, bus_value_o, end_of_transaction_o);
    end
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop = steady || ($urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    tracker = new();
    steady = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    op_i = OP_INIT;
    col_first_i = '0;
    row_first_i = '0;
    col_past_end_i = '0;
    row_past_end_i = '0;
    pixel_value_i = '0;
    flag_one_i = 1'b0;
    flag_two_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: offsets at opposite extremes, inversion in the start-up sequence.
    apply_settings(1, 1, 0, 1, 1, 9'd255, 9'h100);
    put(OP_PIXEL, 0, 0, 0, 0, 8'hFF, 0, 0);          // no window yet: dropped
    put(OP_MIRROR, 0, 0, 0, 0, 0, 1, 1);             // edits the reset address mode
    put(OP_INIT, 0, 0, 0, 0, 0, 0, 0);
    put(OP_SWAP, 0, 0, 0, 0, 0, 0, 0);
    put(OP_WINDOW, 0, 0, 1024, 1024, 0, 0, 0);       // full panel, largest count
    put(OP_PIXEL, 1023, 1023, 1024, 1024, 8'h00, 1, 1);
    put(OP_PIXEL, 0, 0, 0, 0, 8'hFF, 0, 0);
    put(OP_INVERT, 0, 0, 0, 0, 0, 1, 0);             // abandons the open stream
    put(OP_INVERT, 0, 0, 0, 0, 0, 0, 0);
    put(OP_WINDOW, 1023, 1023, 1024, 1024, 0, 0, 0); // one pixel, two bytes
    put(OP_PIXEL, 0, 0, 0, 0, 8'hA5, 0, 0);
    put(OP_PIXEL, 0, 0, 0, 0, 8'h5A, 0, 0);          // closes the transaction
    put(OP_PIXEL, 0, 0, 0, 0, 8'h3C, 0, 0);          // count spent: dropped
    put(OP_WINDOW, 5, 0, 5, 3, 0, 0, 0);             // zero width
    put(OP_PIXEL, 0, 0, 0, 0, 8'h81, 0, 0);
    put(OP_WINDOW, 1023, 1023, 0, 0, 0, 0, 0);       // reversed corners
    put(OP_ONOFF, 0, 0, 0, 0, 0, 0, 0);
    put(OP_ONOFF, 0, 0, 0, 0, 0, 1, 0);
    put(OP_SLEEP, 0, 0, 0, 0, 0, 1, 0);
    put(OP_SLEEP, 0, 0, 0, 0, 0, 0, 0);
    put(OP_MIRROR, 0, 0, 0, 0, 0, 0, 1);
    put(OP_SWAP, 0, 0, 0, 0, 0, 1, 0);

    // Random phases, each under its own register settings.
    for (int p = 0; p < 4; p++) begin
      wait_drained(SETTLE_CYCLES);
      case (p)
        0: apply_settings(0, 0, 0, 0, 0, 9'd0, 9'd0);
        1: apply_settings(1, 1, 1, 1, 1, 9'h100, 9'd255);
        default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 9'($urandom), 9'($urandom));
      endcase
      steady = (p == 1);
      random_phase(ITEMS_PER_PHASE, p == 2);
    end
    steady = 1'b0;

    wait_drained(SETTLE_CYCLES);
    if (tracker.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
